### design/xpl_pkg.sv
// ----------------------------------------------------------------------------
// xpl_pkg: shared types and constants for the cross-correlation peak finder
// Fixed port widths, the sequencer-to-MAC control group and the state type.
// ----------------------------------------------------------------------------
`default_nettype none

package xpl_pkg;

   localparam int SAMPLE_W   = 16;   // width of sample_a / sample_b on the port
   localparam int LAG_OUT_W  = 11;   // width of best_lag on the port
   localparam int PEAK_OUT_W = 42;   // width of peak_value on the port

   // control that travels with every product term through the MAC pipeline
   typedef struct packed {
      logic issue;   // term is valid
      logic first;   // first term of its lag
      logic last;    // last term of its lag
      logic head;    // term belongs to the first lag of the scan
      logic tail;    // term belongs to the last lag of the scan
   } term_ctl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_START,
      ST_RUN,
      ST_HOLD
   } xpl_state_type;

endpackage

`default_nettype wire

### design/xpl_if.sv
// ----------------------------------------------------------------------------
// xpl_if: channel interfaces for the cross-correlation peak finder
// Sample-pair request channel and lag/peak response channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface xpl_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [xpl_pkg::SAMPLE_W-1:0] sample_a;
   logic signed [xpl_pkg::SAMPLE_W-1:0] sample_b;
   logic                                last;

   modport source (output valid, output sample_a, output sample_b, output last,
                   input ready);
   modport sink   (input valid, input sample_a, input sample_b, input last,
                   output ready);
endinterface

interface xpl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [xpl_pkg::LAG_OUT_W-1:0]  best_lag;
   logic signed [xpl_pkg::PEAK_OUT_W-1:0] peak_value;

   modport source (output valid, output best_lag, output peak_value, input ready);
   modport sink   (input valid, input best_lag, input peak_value, output ready);
endinterface

`default_nettype wire

### design/xpl_ram.sv
// ----------------------------------------------------------------------------
// xpl_ram: sample store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module xpl_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/xpl_seq.sv
// ----------------------------------------------------------------------------
// xpl_seq: lag and term sequencer
// Walks every lag from -(N-1) to N-1 and, within a lag, every overlapping
// sample pair, issuing one pair of store addresses per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xpl_seq #(
   parameter int MAX_LEN = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic [$clog2(MAX_LEN+1)-1:0]           len,
   output xpl_pkg::term_ctl_type                       ctl,
   output logic      [$clog2(MAX_LEN)-1:0]             addr_a,
   output logic      [$clog2(MAX_LEN)-1:0]             addr_b,
   output logic signed [$clog2(MAX_LEN):0]             lag
);

   localparam int AW    = $clog2(MAX_LEN);
   localparam int CW    = $clog2(MAX_LEN + 1);
   localparam int LAG_W = AW + 1;

   logic                    active_ff, active_in;
   logic                    first_ff, first_in;
   logic signed [LAG_W-1:0] k_ff, k_in;
   logic signed [LAG_W-1:0] lenm1_ff, lenm1_in;
   logic [CW-1:0]           len_ff, len_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic [AW-1:0]           ia_ff, ia_in;
   logic [AW-1:0]           ib_ff, ib_in;

   logic signed [LAG_W-1:0] k_nx;
   logic [LAG_W-1:0]        mag_nx;
   logic                    last_term;
   logic                    final_lag;

   assign last_term = (rem_ff == CW'(1));
   assign final_lag = (k_ff == lenm1_ff);
   assign k_nx      = k_ff + LAG_W'(1);
   assign mag_nx    = k_nx[LAG_W-1] ? LAG_W'(-k_nx) : LAG_W'(k_nx);

   always_comb begin
      active_in = active_ff;
      first_in  = first_ff;
      k_in      = k_ff;
      lenm1_in  = lenm1_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      ia_in     = ia_ff;
      ib_in     = ib_ff;
      if (start) begin
         // begin at the most negative lag: one term, a[0]*b[N-1]
         len_in    = len;
         lenm1_in  = LAG_W'(len - CW'(1));
         active_in = 1'b1;
         first_in  = 1'b1;
         k_in      = -lenm1_in;
         ia_in     = '0;
         ib_in     = lenm1_in[AW-1:0];
         rem_in    = CW'(1);
      end else if (active_ff) begin
         if (last_term) begin
            if (final_lag) begin
               active_in = 1'b0;
            end else begin
               // advance to the next lag
               first_in = 1'b1;
               k_in     = k_nx;
               ia_in    = k_nx[LAG_W-1] ? '0 : mag_nx[AW-1:0];
               ib_in    = k_nx[LAG_W-1] ? mag_nx[AW-1:0] : '0;
               rem_in   = len_ff - mag_nx[CW-1:0];
            end
         end else begin
            first_in = 1'b0;
            ia_in    = ia_ff + AW'(1);
            ib_in    = ib_ff + AW'(1);
            rem_in   = rem_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      k_ff     <= k_in;
      lenm1_ff <= lenm1_in;
      len_ff   <= len_in;
      rem_ff   <= rem_in;
      ia_ff    <= ia_in;
      ib_ff    <= ib_in;
   end

   always_comb begin
      ctl.issue = active_ff;
      ctl.first = first_ff;
      ctl.last  = last_term;
      ctl.head  = (k_ff == -lenm1_ff);
      ctl.tail  = last_term && final_lag;
   end

   assign addr_a = ia_ff;
   assign addr_b = ib_ff;
   assign lag    = k_ff;

endmodule

`default_nettype wire

### design/xpl_mac.sv
// ----------------------------------------------------------------------------
// xpl_mac: shared multiply-accumulate and peak tracker
// Multiplies one sample pair per cycle, sums each lag's terms and keeps the
// first maximum over the lags in scan order.
// ----------------------------------------------------------------------------
`default_nettype none

module xpl_mac #(
   parameter int SAMPLE_BITS = 16,
   parameter int LAG_W       = 11,
   parameter int ACC_W       = 43
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire xpl_pkg::term_ctl_type         ctl,
   input  wire logic signed [LAG_W-1:0]       lag,
   input  wire logic signed [SAMPLE_BITS-1:0] data_a,
   input  wire logic signed [SAMPLE_BITS-1:0] data_b,
   output logic                               done,
   output logic signed [LAG_W-1:0]            best_lag,
   output logic signed [ACC_W-1:0]            best_val
);

   localparam int PW = 2 * SAMPLE_BITS;

   xpl_pkg::term_ctl_type   c1_ff, c2_ff, c3_ff;
   logic signed [LAG_W-1:0] l1_ff, l2_ff, l3_ff;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_base;
   logic signed [ACC_W-1:0] best_val_ff, best_val_in;
   logic signed [LAG_W-1:0] best_lag_ff, best_lag_in;
   logic                    done_ff, done_in;
   logic                    lag_end;

   assign prod_in  = data_a * data_b;
   assign acc_base = c2_ff.first ? ACC_W'(0) : acc_ff;
   assign acc_in   = acc_base + ACC_W'(prod_ff);
   assign lag_end  = c3_ff.issue && c3_ff.last;

   always_comb begin
      best_val_in = best_val_ff;
      best_lag_in = best_lag_ff;
      done_in     = 1'b0;
      if (lag_end) begin
         // strict compare keeps the earliest lag on ties
         if (c3_ff.head || (acc_ff > best_val_ff)) begin
            best_val_in = acc_ff;
            best_lag_in = l3_ff;
         end
         done_in = c3_ff.tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff   <= '0;
         c2_ff   <= '0;
         c3_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         c1_ff   <= ctl;
         c2_ff   <= c1_ff;
         c3_ff   <= c2_ff;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      l1_ff       <= lag;
      l2_ff       <= l1_ff;
      l3_ff       <= l2_ff;
      prod_ff     <= prod_in;
      best_val_ff <= best_val_in;
      best_lag_ff <= best_lag_in;
      if (c2_ff.issue) begin
         acc_ff <= acc_in;
      end
   end

   assign done     = done_ff;
   assign best_lag = best_lag_ff;
   assign best_val = best_val_ff;

endmodule

`default_nettype wire

### design/xcorr_peak_lag.sv
// ----------------------------------------------------------------------------
// xcorr_peak_lag: lag of the peak of a linear cross-correlation
// Loads two sample sequences, then scans all lags with one shared MAC and
// reports the lag of the first maximum and the correlation value there.
// ----------------------------------------------------------------------------
//  channel   direction  payload                          accepted when
//  req_chan  in         sample_a, sample_b, last         valid & ready
//  rsp_chan  out        best_lag, peak_value             valid & ready
//
//  Loading takes one item per cycle. An item with last set starts the scan:
//  the single multiplier takes one product term per cycle, N*N terms over
//  all 2N-1 lags, and the result then passes the start state and the MAC
//  pipeline on its way to rsp_chan.valid, N = pairs loaded.
//  req_chan is not ready during the scan. A finished result waits in the
//  output register; loading of the next sequence goes on meanwhile.
//  Reset clears control only; the sample stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module xcorr_peak_lag #(
   parameter int MAX_LEN     = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   xpl_req_if.sink    req_chan,
   xpl_rsp_if.source  rsp_chan
);

   localparam int AW    = $clog2(MAX_LEN);
   localparam int CW    = $clog2(MAX_LEN + 1);
   localparam int LAG_W = AW + 1;
   localparam int ACC_W = 2 * SAMPLE_BITS + AW + 1;
   localparam int EW    = (SAMPLE_BITS > xpl_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                            : xpl_pkg::SAMPLE_W;
   localparam int LX    = (LAG_W > xpl_pkg::LAG_OUT_W) ? LAG_W : xpl_pkg::LAG_OUT_W;
   localparam int PX    = (ACC_W > xpl_pkg::PEAK_OUT_W) ? ACC_W
                                                        : xpl_pkg::PEAK_OUT_W;
   localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

   xpl_pkg::xpl_state_type state_ff, state_in;

   logic [CW-1:0] fill_ff, fill_in;
   logic          accept;
   logic          wr_en;
   logic          seq_start;
   logic          rsp_load;
   logic [EW-1:0] a_ext, b_ext;

   xpl_pkg::term_ctl_type     ctl;
   logic [AW-1:0]             addr_a, addr_b;
   logic signed [LAG_W-1:0]   lag;
   logic [SAMPLE_BITS-1:0]    rd_a, rd_b;
   logic                      mac_done;
   logic signed [LAG_W-1:0]   best_lag;
   logic signed [ACC_W-1:0]   best_val;
   logic signed [LX-1:0]      lag_ext;
   logic signed [PX-1:0]      peak_ext;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [xpl_pkg::LAG_OUT_W-1:0]         rsp_lag_ff;
   logic [xpl_pkg::PEAK_OUT_W-1:0]        rsp_peak_ff;

   // sample = two's complement of the low SAMPLE_BITS bits of the field
   assign a_ext  = EW'($unsigned(req_chan.sample_a));
   assign b_ext  = EW'($unsigned(req_chan.sample_b));
   assign accept = req_chan.valid && req_chan.ready;
   assign wr_en  = accept && (fill_ff < FULL);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xpl_pkg::ST_LOAD: begin
            if (accept && req_chan.last) begin
               state_in = xpl_pkg::ST_START;
            end
         end
         xpl_pkg::ST_START: begin
            state_in = xpl_pkg::ST_RUN;
         end
         xpl_pkg::ST_RUN: begin
            if (mac_done) begin
               state_in = xpl_pkg::ST_HOLD;
            end
         end
         xpl_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = xpl_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = xpl_pkg::ST_LOAD;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      seq_start      = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         xpl_pkg::ST_LOAD:  req_chan.ready = 1'b1;
         xpl_pkg::ST_START: seq_start      = 1'b1;
         xpl_pkg::ST_RUN:   ;
         xpl_pkg::ST_HOLD:  rsp_load       = !rsp_valid_ff || rsp_chan.ready;
         default:           ;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (seq_start) begin
         fill_in = '0;
      end else if (wr_en) begin
         fill_in = fill_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xpl_pkg::ST_LOAD;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign lag_ext  = LX'(best_lag);
   assign peak_ext = PX'(best_val);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_lag_ff  <= lag_ext[xpl_pkg::LAG_OUT_W-1:0];
         rsp_peak_ff <= peak_ext[xpl_pkg::PEAK_OUT_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.best_lag   = rsp_lag_ff;
   assign rsp_chan.peak_value = rsp_peak_ff;

   xpl_ram #(
      .DEPTH (MAX_LEN),
      .WIDTH (SAMPLE_BITS)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (a_ext[SAMPLE_BITS-1:0]),
      .rd_en   (ctl.issue),
      .rd_addr (addr_a),
      .rd_data (rd_a)
   );

   xpl_ram #(
      .DEPTH (MAX_LEN),
      .WIDTH (SAMPLE_BITS)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (b_ext[SAMPLE_BITS-1:0]),
      .rd_en   (ctl.issue),
      .rd_addr (addr_b),
      .rd_data (rd_b)
   );

   xpl_seq #(
      .MAX_LEN (MAX_LEN)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (seq_start),
      .len    (fill_ff),
      .ctl    (ctl),
      .addr_a (addr_a),
      .addr_b (addr_b),
      .lag    (lag)
   );

   xpl_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LAG_W       (LAG_W),
      .ACC_W       (ACC_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .lag      (lag),
      .data_a   ($signed(rd_a)),
      .data_b   ($signed(rd_b)),
      .done     (mac_done),
      .best_lag (best_lag),
      .best_val (best_val)
   );

endmodule

`default_nettype wire

### tb/tb_xcorr_peak_lag.sv
// ----------------------------------------------------------------------------
// tb_xcorr_peak_lag: self-checking bench for the cross-correlation peak finder
// Streams sample-pair loads into the block, predicts the peak lag and value
// of each load by direct correlation over every lag, and checks each
// response in order. Sender and receiver idle at random; the rates swap
// between phases, and the last phase runs with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_xcorr_peak_lag;

   typedef logic signed [xpl_pkg::SAMPLE_W-1:0]   sample_type;
   typedef logic signed [xpl_pkg::LAG_OUT_W-1:0]  lag_type;
   typedef logic signed [xpl_pkg::PEAK_OUT_W-1:0] peak_type;

   localparam int PAIR_DEPTH = 1024;
   localparam sample_type SAMPLE_MIN = 16'sh8000;
   localparam sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam int SETTLE_CYCLES = 50;

   typedef struct packed {
      lag_type  lag;
      peak_type peak;
   } peak_lag_type;

   typedef enum int {
      FILL_WIDE,
      FILL_NARROW,
      FILL_EDGE
   } fill_style_type;

   logic clock;
   logic reset;

   xpl_req_if req_chan ();
   xpl_rsp_if rsp_chan ();

   xcorr_peak_lag #(
      .MAX_LEN     (PAIR_DEPTH),
      .SAMPLE_BITS (xpl_pkg::SAMPLE_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // model copy of the sample stores and the load in progress
   shortint      sig_a [PAIR_DEPTH];
   shortint      sig_b [PAIR_DEPTH];
   int           stored_pairs;
   peak_lag_type pending_peaks[$];
   int           mismatch_count;
   int           send_idle_pct;
   int           recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic peak_lag_type predict_peak_lag(int len);
      peak_lag_type res;
      longint       acc;
      longint       best_v;
      int           best_k;
      int           lo;
      int           hi;
      best_k = -(len - 1);
      best_v = 0;
      for (int k = -(len - 1); k <= len - 1; k++) begin
         acc = 0;
         lo  = (k < 0) ? -k : 0;
         hi  = (k > 0) ? len - k : len;
         for (int n = lo; n < hi; n++)
            acc += longint'(sig_a[n + k]) * longint'(sig_b[n]);
         // strict compare keeps the most negative lag on ties
         if (k == -(len - 1) || acc > best_v) begin
            best_v = acc;
            best_k = k;
         end
      end
      res.lag  = lag_type'(best_k);
      res.peak = peak_type'(best_v);
      return res;
   endfunction

   task automatic send_pair(input sample_type a,
                            input sample_type b,
                            input logic       lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.sample_a <= a;
      req_chan.sample_b <= b;
      req_chan.last     <= lst;
      do @(posedge clock); while (!req_chan.ready);
      // drop pairs beyond the store depth, but still honor last
      if (stored_pairs < PAIR_DEPTH) begin
         sig_a[stored_pairs] = a;
         sig_b[stored_pairs] = b;
         stored_pairs++;
      end
      if (lst) begin
         pending_peaks.push_back(predict_peak_lag(stored_pairs));
         stored_pairs = 0;
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_peaks.size() != 0);
   endtask

   function automatic sample_type rand_sample(fill_style_type style);
      sample_type s;
      case (style)
         FILL_NARROW: s = sample_type'(int'($urandom_range(4)) - 2);
         FILL_EDGE: begin
            case ($urandom_range(3))
               0:       s = SAMPLE_MIN;
               1:       s = SAMPLE_MAX;
               2:       s = '0;
               default: s = '1;
            endcase
         end
         default:     s = sample_type'($urandom);
      endcase
      return s;
   endfunction

   task automatic send_load(int n, fill_style_type style);
      for (int i = 0; i < n; i++)
         send_pair(rand_sample(style), rand_sample(style), i == n - 1);
   endtask

   task automatic test_single_pair();
      send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
      send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
   endtask

   task automatic test_field_extremes();
      send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_pair('1, '0, 1'b0);
      send_pair('0, '1, 1'b1);
   endtask

   task automatic test_ties();
      // all zero: every lag ties, the most negative wins
      send_pair('0, '0, 1'b0);
      send_pair('0, '0, 1'b0);
      send_pair('0, '0, 1'b1);
      // equal peaks at lag 0 and lag 2
      send_pair(16'sd1, 16'sd1, 1'b0);
      send_pair('0, '0, 1'b0);
      send_pair(16'sd1, '0, 1'b1);
   endtask

   task automatic test_lag_extremes();
      send_pair(16'sd5, '0, 1'b0);
      send_pair('0, '0, 1'b0);
      send_pair('0, 16'sd5, 1'b1);
      send_pair('0, 16'sd5, 1'b0);
      send_pair('0, '0, 1'b0);
      send_pair(16'sd5, '0, 1'b1);
   endtask

   task automatic test_random_loads(int item_budget, int min_loads);
      int sent;
      int loads;
      int n;
      int pick;
      fill_style_type style;
      sent  = 0;
      loads = 0;
      while (sent < item_budget || loads < min_loads) begin
         pick = $urandom_range(99);
         if (pick < 70)
            n = $urandom_range(8, 1);
         else if (pick < 95)
            n = $urandom_range(32, 9);
         else
            n = $urandom_range(64, 33);
         pick = $urandom_range(99);
         if (pick < 60)
            style = FILL_WIDE;
         else if (pick < 80)
            style = FILL_NARROW;
         else
            style = FILL_EDGE;
         send_load(n, style);
         sent += n;
         loads++;
         if (loads % 9 == 0)
            wait_drained();
      end
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      peak_lag_type exp_peak;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_peaks.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected result: expected none, actual lag %0d peak %0d",
                     $time, rsp_chan.best_lag, rsp_chan.peak_value);
         end else begin
            exp_peak = pending_peaks.pop_front();
            if (rsp_chan.best_lag !== exp_peak.lag) begin
               mismatch_count++;
               $display("%0t best_lag: expected %0d, actual %0d",
                        $time, exp_peak.lag, rsp_chan.best_lag);
            end
            if (rsp_chan.peak_value !== exp_peak.peak) begin
               mismatch_count++;
               $display("%0t peak_value: expected %0d, actual %0d",
                        $time, exp_peak.peak, rsp_chan.peak_value);
            end
         end
      end
   end

   initial begin
      mismatch_count    = 0;
      stored_pairs      = 0;
      send_idle_pct     = 30;
      recv_idle_pct     = 70;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.sample_a <= '0;
      req_chan.sample_b <= '0;
      req_chan.last     <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_single_pair();
      test_field_extremes();
      test_ties();
      test_lag_extremes();
      test_random_loads(80, 6);
      wait_drained();

      send_idle_pct = 70;
      recv_idle_pct = 30;
      test_random_loads(80, 6);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_loads(80, 6);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
design/xpl_pkg.sv
design/xpl_if.sv
design/xpl_ram.sv
design/xpl_seq.sv
design/xpl_mac.sv
design/xcorr_peak_lag.sv
tb/tb_xcorr_peak_lag.sv
